[rtl/wrc_pkg.sv]
`default_nettype none

package wrc_pkg;

  // lane count as shipped, and the most lanes one request can carry
  localparam int unsigned BYTES_PER_ITEM_DEF = 8;
  localparam int unsigned MAX_LANES          = 8;

  // port field widths
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned S_TDATA_W = 72;  // 64 + 4, padded to whole bytes
  localparam int unsigned M_TDATA_W = 40;  // 32 + 7, padded to whole bytes

  // words lying wholly inside one request: at most half the lanes
  localparam int unsigned MID_W = 3;
  // words added by one request: the leading close plus the inner words
  localparam int unsigned ADD_W = 4;

  // byte class boundaries
  localparam logic [7:0] SEP_LO_EXCL   = 8'h08;
  localparam logic [7:0] SEP_HI_EXCL   = 8'h0E;
  localparam logic [7:0] SEP_SPACE     = 8'h20;
  localparam logic [7:0] PRINT_LO      = 8'h21;
  localparam logic [7:0] PRINT_HI      = 8'h7E;

  // summary of one request, independent of the carried scan state
  typedef struct packed {
    logic             start;          // clear scan state first
    logic             any;            // at least one byte scanned
    logic             first_sep;      // first byte is a separator
    logic             has_sep;        // request holds a separator
    logic             head_nonempty;  // non-separators before the first separator
    logic             head_print;     // a printable byte before the first separator
    logic [MID_W-1:0] mid_words;      // printable runs opened and closed inside
    logic             tail_nonempty;  // last byte is not a separator
    logic             tail_print;     // run after the last separator is printable
  } item_sum_t;

  function automatic logic is_sep(input logic [7:0] b);
    return ((b > SEP_LO_EXCL) && (b < SEP_HI_EXCL)) || (b == SEP_SPACE);
  endfunction

  function automatic logic is_print(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

endpackage

`default_nettype wire

[rtl/wrc_front.sv]
`default_nettype none

module wrc_front #(
  parameter int unsigned BYTES_PER_ITEM = wrc_pkg::BYTES_PER_ITEM_DEF
) (
  input  wire logic                         start_req_i,
  input  wire logic [wrc_pkg::DATA_W-1:0]   data_bytes_i,
  input  wire logic [wrc_pkg::COUNT_W-1:0]  byte_count_i,
  output wrc_pkg::item_sum_t                sum_o
);
  import wrc_pkg::*;

  localparam int unsigned LANES = (BYTES_PER_ITEM > MAX_LANES) ? MAX_LANES : BYTES_PER_ITEM;

  logic [LANES-1:0] lane_valid;
  logic [LANES-1:0] lane_sep;
  logic [LANES-1:0] lane_print;

  // per-lane classification, lanes past the count are masked off
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_valid[k] = (COUNT_W'(k) < byte_count_i);
      lane_sep[k]   = is_sep(data_bytes_i[8*k +: 8]);
      lane_print[k] = is_print(data_bytes_i[8*k +: 8]);
    end
  end

  // in-order scan of the lanes into a state-free summary
  always_comb begin
    logic             after_sep;
    logic             cur_nonempty;
    logic             cur_print;
    logic             head_ne;
    logic             head_pr;
    logic [MID_W-1:0] mid;
    after_sep    = 1'b0;
    cur_nonempty = 1'b0;
    cur_print    = 1'b0;
    head_ne      = 1'b0;
    head_pr      = 1'b0;
    mid          = '0;
    for (int k = 0; k < LANES; k++) begin
      if (lane_valid[k]) begin
        if (lane_sep[k]) begin
          if (!after_sep) begin
            head_ne = cur_nonempty;
            head_pr = cur_print;
          end else if (cur_nonempty && cur_print) begin
            mid = mid + MID_W'(1);
          end
          after_sep    = 1'b1;
          cur_nonempty = 1'b0;
          cur_print    = 1'b0;
        end else begin
          cur_nonempty = 1'b1;
          cur_print    = cur_print | lane_print[k];
        end
      end
    end
    sum_o.start         = start_req_i;
    sum_o.any           = lane_valid[0];
    sum_o.first_sep     = lane_sep[0];
    sum_o.has_sep       = after_sep;
    sum_o.head_nonempty = after_sep ? head_ne : cur_nonempty;
    sum_o.head_print    = after_sep ? head_pr : cur_print;
    sum_o.mid_words     = mid;
    sum_o.tail_nonempty = cur_nonempty;
    sum_o.tail_print    = cur_print;
  end

endmodule

`default_nettype wire

[rtl/wrc_queue.sv]
`default_nettype none

module wrc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire wrc_pkg::item_sum_t push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output wrc_pkg::item_sum_t      pop_data_o
);
  import wrc_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_sum_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == CNT_W'(DEPTH));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // summary storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/wrc_back.sv]
`default_nettype none

module wrc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        sum_valid_i,
  input  wire wrc_pkg::item_sum_t          sum_i,
  output logic                             sum_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [wrc_pkg::TOTAL_W-1:0]      word_total_o,
  output logic                             any_byte_seen_o,
  output logic                             began_in_run_o,
  output logic                             inside_run_o,
  output logic                             open_run_printable_o,
  output logic                             separator_seen_o,
  output logic                             lead_run_closed_o,
  output logic                             lead_run_printable_o
);
  import wrc_pkg::*;

  logic [TOTAL_W-1:0] cnt_q, cnt_d;
  logic seen_q, seen_d;
  logic si_q, si_d;
  logic inrun_q, inrun_d;
  logic rp_q, rp_d;
  logic ss_q, ss_d;
  logic lc_q, lc_d;
  logic lp_q, lp_d;
  logic out_valid_q, out_valid_d;

  // take a summary whenever the shown result is free or being taken
  assign sum_pop_o = sum_valid_i && (!out_valid_q || out_ready_i);

  // fold one summary into the carried scan state
  always_comb begin
    logic [TOTAL_W-1:0] b_cnt;
    logic               b_seen, b_si, b_inrun, b_rp, b_ss, b_lc, b_lp;
    logic               closes, pr0;
    logic [ADD_W-1:0]   add;
    logic [TOTAL_W:0]   sum;
    b_cnt   = sum_i.start ? '0 : cnt_q;
    b_seen  = sum_i.start ? 1'b0 : seen_q;
    b_si    = sum_i.start ? 1'b0 : si_q;
    b_inrun = sum_i.start ? 1'b0 : inrun_q;
    b_rp    = sum_i.start ? 1'b0 : rp_q;
    b_ss    = sum_i.start ? 1'b0 : ss_q;
    b_lc    = sum_i.start ? 1'b0 : lc_q;
    b_lp    = sum_i.start ? 1'b0 : lp_q;
    closes  = b_inrun || sum_i.head_nonempty;
    pr0     = b_rp || sum_i.head_print;
    add     = ADD_W'(sum_i.mid_words) + ADD_W'(closes && pr0);
    sum     = {1'b0, b_cnt} + (TOTAL_W + 1)'(add);
    cnt_d   = b_cnt;
    seen_d  = b_seen;
    si_d    = b_si;
    inrun_d = b_inrun;
    rp_d    = b_rp;
    ss_d    = b_ss;
    lc_d    = b_lc;
    lp_d    = b_lp;
    if (sum_i.any) begin
      seen_d = 1'b1;
      si_d   = b_seen ? b_si : !sum_i.first_sep;
      if (!sum_i.has_sep) begin
        inrun_d = 1'b1;
        rp_d    = pr0;
      end else begin
        cnt_d   = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        if (!b_ss && si_d && closes) begin
          lc_d = 1'b1;
          lp_d = pr0;
        end
        ss_d    = 1'b1;
        inrun_d = sum_i.tail_nonempty;
        rp_d    = sum_i.tail_print;
      end
    end
  end

  // result slot handshake
  always_comb begin
    if (sum_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      si_q        <= 1'b0;
      inrun_q     <= 1'b0;
      rp_q        <= 1'b0;
      ss_q        <= 1'b0;
      lc_q        <= 1'b0;
      lp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (sum_pop_o) begin
        cnt_q   <= cnt_d;
        seen_q  <= seen_d;
        si_q    <= si_d;
        inrun_q <= inrun_d;
        rp_q    <= rp_d;
        ss_q    <= ss_d;
        lc_q    <= lc_d;
        lp_q    <= lp_d;
      end
    end
  end

  // the carried state is the shown result
  assign out_valid_o          = out_valid_q;
  assign word_total_o         = cnt_q;
  assign any_byte_seen_o      = seen_q;
  assign began_in_run_o       = si_q;
  assign inside_run_o         = inrun_q;
  assign open_run_printable_o = rp_q;
  assign separator_seen_o     = ss_q;
  assign lead_run_closed_o    = lc_q;
  assign lead_run_printable_o = lp_q;

endmodule

`default_nettype wire

[rtl/word_run_counter.sv]
// word_run_counter: byte-mode word counter with chunk-merge flags.
// input stream: each request carries up to eight bytes (first byte lowest),
// a valid byte count and, in tuser, a start flag that clears all scan state
// before the bytes. output stream: one result per request, showing the word
// total and the seven scan flags after that request.
// a front stage classifies the lanes of a request into a state-free summary,
// a two-entry queue holds summaries, and a back stage folds one summary into
// the carried state per cycle, so throughput is one request per cycle while
// m_axis_tready is high. a request passes a queue entry and then the result
// register on its way out. the input stays ready while the queue has room,
// so a stalled receiver is absorbed by the result register and the queue
// before s_axis_tready drops; results are held stable until taken.
// reset clears the word total, all flags and the queue; the first result
// after reset reflects only the requests accepted since.
`default_nettype none

module word_run_counter #(
  parameter int unsigned BYTES_PER_ITEM = wrc_pkg::BYTES_PER_ITEM_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // data_bytes [63:0], byte_count [67:64], zero [71:68]
  input  wire logic [wrc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // start_req [0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // word_total [31:0], any_byte_seen [32], began_in_run [33], inside_run [34],
  // open_run_printable [35], separator_seen [36], lead_run_closed [37],
  // lead_run_printable [38], zero [39]
  output logic [wrc_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
  import wrc_pkg::*;

  item_sum_t          front_sum;
  item_sum_t          queue_sum;
  logic               queue_full;
  logic               queue_valid;
  logic               queue_pop;
  logic [TOTAL_W-1:0] word_total;
  logic               any_byte_seen, began_in_run, inside_run, open_run_printable;
  logic               separator_seen, lead_run_closed, lead_run_printable;

  assign s_axis_tready = !queue_full;

  // request classification
  wrc_front #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_front (
    .start_req_i (s_axis_tuser),
    .data_bytes_i(s_axis_tdata[DATA_W-1:0]),
    .byte_count_i(s_axis_tdata[DATA_W +: COUNT_W]),
    .sum_o       (front_sum)
  );

  // summary queue between the two sides
  wrc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_data_i(front_sum),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_sum)
  );

  // state fold and result register
  wrc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sum_valid_i         (queue_valid),
    .sum_i               (queue_sum),
    .sum_pop_o           (queue_pop),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .word_total_o        (word_total),
    .any_byte_seen_o     (any_byte_seen),
    .began_in_run_o      (began_in_run),
    .inside_run_o        (inside_run),
    .open_run_printable_o(open_run_printable),
    .separator_seen_o    (separator_seen),
    .lead_run_closed_o   (lead_run_closed),
    .lead_run_printable_o(lead_run_printable)
  );

  // result packing
  assign m_axis_tdata = {1'b0, lead_run_printable, lead_run_closed, separator_seen,
                         open_run_printable, inside_run, began_in_run, any_byte_seen,
                         word_total};

endmodule

`default_nettype wire
